// File: sv/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

	// Default fraction width: 1 << FRAC_BITS_DEF stands for 1.0.
	localparam int FRAC_BITS_DEF = 12;

	localparam int HUE_W = 12;
	localparam int REG_W = 13;
	localparam int CH_W  = 5;
	localparam int PIX_W = 16;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = 1'b1;

	localparam logic [REG_W-1:0] SAT_RST   = 13'd4096;
	localparam logic [REG_W-1:0] LIGHT_RST = 13'd2048;

	localparam logic [CH_W-1:0] CH_MAX = 5'd31;
	localparam logic ALPHA = 1'b1;

	// Register stages from input to output.
	localparam int NSTG = 5;

	// Color lanes.
	localparam int NLANE = 3;
	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;

endpackage

`default_nettype wire

// File: sv/hsl_hue_if.sv
`default_nettype none

interface hsl_hue_if import hsl_pkg::*;;
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;

	modport source (output valid, output hue, input ready);
	modport sink (input valid, input hue, output ready);
endinterface

`default_nettype wire

// File: sv/hsl_pix_if.sv
`default_nettype none

interface hsl_pix_if import hsl_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;

	modport source (output valid, output pixel, output red, output green, output blue,
		input ready);
	modport sink (input valid, input pixel, input red, input green, input blue,
		output ready);
endinterface

`default_nettype wire

// File: sv/hsl_to_rgb1555.sv
// HSL to RGB1555 converter. Each hue word (a fraction of a turn) is turned into a packed
// pixel with alpha in bit 15, blue in 14:10, green in 9:5 and red in 4:0, using the
// saturation and lightness held in two configuration registers (index 0 and 1, Q12 by
// default, values above one act as one). The datapath is five register stages deep: the
// L*S multiply, the m1/m2 and sextant decode, the per-channel ramp multiply, the
// numerator sum, and the scale by 31 that feeds the output register. One hue is taken in
// every cycle while the output side keeps taking pixels. Write the registers only while
// no hue is in flight.
`default_nettype none

module hsl_to_rgb1555 import hsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	hsl_hue_if.sink                   hue_chan,
	hsl_pix_if.source                 pixel_chan
);
	logic [FRAC_BITS:0] sat;
	logic [FRAC_BITS:0] light;
	logic [NSTG-1:0]    en;
	logic [FRAC_BITS:0] d_s2;
	logic [FRAC_BITS:0] base_s2 [NLANE];
	logic [FRAC_BITS:0] x_s2 [NLANE];
	logic [CH_W-1:0]    ch_s5 [NLANE];

	hsl_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.sat    (sat),
		.light  (light)
	);

	hsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_chan.valid),
		.out_ready (pixel_chan.ready),
		.in_ready  (hue_chan.ready),
		.out_valid (pixel_chan.valid),
		.en        (en)
	);

	hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.en      (en[1:0]),
		.hue     (hue_chan.hue),
		.sat     (sat),
		.light   (light),
		.d_s2    (d_s2),
		.base_s2 (base_s2),
		.x_s2    (x_s2)
	);

	for (genvar c = 0; c < NLANE; c++) begin : g_lane
		hsl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk   (clk),
			.en    (en[4:2]),
			.d     (d_s2),
			.base  (base_s2[c]),
			.x     (x_s2[c]),
			.ch_s5 (ch_s5[c])
		);
	end

	assign pixel_chan.red   = ch_s5[LANE_RED];
	assign pixel_chan.green = ch_s5[LANE_GREEN];
	assign pixel_chan.blue  = ch_s5[LANE_BLUE];
	assign pixel_chan.pixel = {ALPHA, ch_s5[LANE_BLUE], ch_s5[LANE_GREEN], ch_s5[LANE_RED]};

endmodule

`default_nettype wire

// File: sv/hsl_cfg.sv
`default_nettype none

module hsl_cfg import hsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   we,
	input  wire logic [CFG_IDX_W-1:0]   index,
	input  wire logic [REG_W-1:0]       data,
	output logic      [FRAC_BITS:0]     sat,
	output logic      [FRAC_BITS:0]     light
);
	localparam int CW = FRAC_BITS + 1;
	localparam int LW = (REG_W > CW) ? REG_W : CW;
	localparam logic [LW-1:0] ONE_L = LW'(1) << FRAC_BITS;

	logic [REG_W-1:0] sat_q;
	logic [REG_W-1:0] light_q;
	logic [LW-1:0]    sat_x;
	logic [LW-1:0]    light_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= SAT_RST;
			light_q <= LIGHT_RST;
		end else if (we) begin
			case (index)
				CFG_SAT: begin
					sat_q <= data;
				end
				CFG_LIGHT: begin
					light_q <= data;
				end
				default: begin
				end
			endcase
		end
	end

	// Values above one are used as one.
	assign sat_x   = LW'(sat_q);
	assign light_x = LW'(light_q);
	assign sat     = (sat_x > ONE_L) ? CW'(ONE_L) : CW'(sat_x);
	assign light   = (light_x > ONE_L) ? CW'(ONE_L) : CW'(light_x);

endmodule

`default_nettype wire

// File: sv/hsl_ctrl.sv
`default_nettype none

module hsl_ctrl import hsl_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            out_ready,
	output logic                 in_ready,
	output logic                 out_valid,
	output logic [NSTG-1:0]      en
);
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   rdy;

	// A stage may load when it is empty or its word moves on in the same cycle.
	always_comb begin
		rdy[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign en        = rdy[NSTG-1:0];
	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NSTG-1];

endmodule

`default_nettype wire

// File: sv/hsl_front.sv
`default_nettype none

module hsl_front import hsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic [1:0]         en,
	input  wire logic [HUE_W-1:0]   hue,
	input  wire logic [FRAC_BITS:0] sat,
	input  wire logic [FRAC_BITS:0] light,
	output logic      [FRAC_BITS:0] d_s2,
	output logic      [FRAC_BITS:0] base_s2 [NLANE],
	output logic      [FRAC_BITS:0] x_s2 [NLANE]
);
	localparam int CW = FRAC_BITS + 1;
	localparam int HW = (FRAC_BITS < HUE_W) ? FRAC_BITS : HUE_W;
	localparam int MW = CW + 2;
	localparam int TW = FRAC_BITS + 4;
	localparam logic signed [MW-1:0] ONE_M  = MW'(1) << FRAC_BITS;
	localparam logic [CW-1:0]        HALF   = CW'(1) << (FRAC_BITS - 1);
	localparam logic [TW-1:0]        ONE_T  = TW'(1) << FRAC_BITS;
	localparam logic [TW-1:0]        TWO_T  = TW'(2) << FRAC_BITS;
	localparam logic [TW-1:0]        THR_T  = TW'(3) << FRAC_BITS;
	localparam logic [TW-1:0]        FOUR_T = TW'(4) << FRAC_BITS;
	localparam logic [TW-1:0]        SIX_T  = TW'(6) << FRAC_BITS;

	logic [2*CW-1:0] ls_full;
	logic [CW-1:0]   l_s1;
	logic [CW-1:0]   s_s1;
	logic [CW-1:0]   ls_s1;
	logic [HW-1:0]   hm_s1;

	logic signed [MW-1:0] l_m;
	logic signed [MW-1:0] s_m;
	logic signed [MW-1:0] ls_m;
	logic signed [MW-1:0] m2_raw;
	logic signed [MW-1:0] m2_c;
	logic signed [MW-1:0] m1_raw;
	logic signed [MW-1:0] m1_c;
	logic [CW-1:0]        m1;
	logic [CW-1:0]        m2;
	logic [TW-1:0]        h6;
	logic [TW-1:0]        hr;
	logic [TW-1:0]        hb;
	logic [TW-1:0]        t [NLANE];
	logic [CW-1:0]        base_c [NLANE];
	logic [CW-1:0]        x_c [NLANE];

	// Stage 1: L*S product, hue reduced to one turn.
	assign ls_full = light * sat;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			l_s1  <= light;
			s_s1  <= sat;
			ls_s1 <= CW'(ls_full >> FRAC_BITS);
			hm_s1 <= hue[HW-1:0];
		end
	end

	// Stage 2: m2, m1 and where each channel lies on the hue ramp.
	always_comb begin
		l_m  = signed'(MW'(l_s1));
		s_m  = signed'(MW'(s_s1));
		ls_m = signed'(MW'(ls_s1));
		if (l_s1 < HALF) begin
			m2_raw = l_m + ls_m;
		end else begin
			m2_raw = l_m + s_m - ls_m;
		end
		if (m2_raw < 0) begin
			m2_c = '0;
		end else if (m2_raw > ONE_M) begin
			m2_c = ONE_M;
		end else begin
			m2_c = m2_raw;
		end
		m1_raw = (l_m <<< 1) - m2_c;
		if (m1_raw < 0) begin
			m1_c = '0;
		end else if (m1_raw > m2_c) begin
			m1_c = m2_c;
		end else begin
			m1_c = m1_raw;
		end
		m1 = CW'(m1_c);
		m2 = CW'(m2_c);
	end

	// Six sextants per turn make the one-third offsets exact.
	assign h6 = (TW'(hm_s1) << 2) + (TW'(hm_s1) << 1);
	assign hr = h6 + TWO_T;
	assign hb = h6 + FOUR_T;

	always_comb begin
		t[LANE_RED]   = (hr >= SIX_T) ? hr - SIX_T : hr;
		t[LANE_GREEN] = h6;
		t[LANE_BLUE]  = (hb >= SIX_T) ? hb - SIX_T : hb;
		for (int c = 0; c < NLANE; c++) begin
			if (t[c] < ONE_T) begin
				base_c[c] = m1;
				x_c[c]    = CW'(t[c]);
			end else if (t[c] < THR_T) begin
				base_c[c] = m2;
				x_c[c]    = '0;
			end else if (t[c] < FOUR_T) begin
				base_c[c] = m1;
				x_c[c]    = CW'(FOUR_T - t[c]);
			end else begin
				base_c[c] = m1;
				x_c[c]    = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s2    <= m2 - m1;
			base_s2 <= base_c;
			x_s2    <= x_c;
		end
	end

endmodule

`default_nettype wire

// File: sv/hsl_lane.sv
`default_nettype none

module hsl_lane import hsl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic [2:0]         en,
	input  wire logic [FRAC_BITS:0] d,
	input  wire logic [FRAC_BITS:0] base,
	input  wire logic [FRAC_BITS:0] x,
	output logic      [CH_W-1:0]    ch_s5
);
	localparam int CW = FRAC_BITS + 1;
	localparam int NW = 2 * FRAC_BITS + 2;
	localparam int SW = NW + 5;
	localparam int QW = SW - 2 * FRAC_BITS;

	logic [2*CW-1:0] prod_s3;
	logic [CW-1:0]   base_s3;
	logic [NW-1:0]   num_s4;
	logic [SW-1:0]   scaled;
	logic [QW-1:0]   q;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s3 <= d * x;
			base_s3 <= base;
		end
	end

	// Channel numerator in units of one squared: base*ONE + (m2-m1)*x.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s4 <= (NW'(base_s3) << FRAC_BITS) + NW'(prod_s3);
		end
	end

	// Times 31, then drop the fraction bits.
	assign scaled = (SW'(num_s4) << 5) - SW'(num_s4);
	assign q      = QW'(scaled >> (2 * FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ch_s5 <= (q > QW'(CH_MAX)) ? CH_MAX : CH_W'(q);
		end
	end

endmodule

`default_nettype wire

// File: sv/hsl_chk.sv
`default_nettype none

module hsl_chk import hsl_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] pixel,
	input wire logic [CH_W-1:0]  red,
	input wire logic [CH_W-1:0]  green,
	input wire logic [CH_W-1:0]  blue
);

	// The alpha bit is set on every delivered pixel.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel[15] == ALPHA)
		else $error("pixel alpha bit clear");

	// The packed pixel agrees with the separate channel fields.
	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel[4:0] == red) && (pixel[9:5] == green) && (pixel[14:10] == blue))
		else $error("pixel packing disagrees with channels");

	// With the output stage empty the pipeline always has room for a new hue.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// A stalled pixel stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel))
		else $error("stalled pixel changed");

endmodule

bind hsl_to_rgb1555 hsl_chk u_hsl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hue_chan.valid),
	.in_ready  (hue_chan.ready),
	.out_valid (pixel_chan.valid),
	.out_ready (pixel_chan.ready),
	.pixel     (pixel_chan.pixel),
	.red       (pixel_chan.red),
	.green     (pixel_chan.green),
	.blue      (pixel_chan.blue)
);

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hsl_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int ONE_Q       = 1 << FRAC_BITS_DEF;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} pixel_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	hsl_hue_if hue_chan ();
	hsl_pix_if pixel_chan ();

	hsl_to_rgb1555 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.hue_chan   (hue_chan),
		.pixel_chan (pixel_chan)
	);

	// Copy of the configuration registers as the block should hold them.
	logic [REG_W-1:0] sat_setting;
	logic [REG_W-1:0] light_setting;

	pixel_word_t expected_pixels[$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on     = 1'b0;
	bit          stalls_on   = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [CH_W-1:0] ramp_level(input longint unsigned lo,
		input longint unsigned hi, input longint unsigned t);
		longint unsigned d;
		longint unsigned one2;
		longint unsigned v;
		d = hi - lo;
		one2 = longint'(ONE_Q) * longint'(ONE_Q);
		if (t < ONE_Q)
			v = (31 * (lo * ONE_Q + d * t)) / one2;
		else if (t < 3 * ONE_Q)
			v = (31 * hi) / ONE_Q;
		else if (t < 4 * ONE_Q)
			v = (31 * (lo * ONE_Q + d * (4 * ONE_Q - t))) / one2;
		else
			v = (31 * lo) / ONE_Q;
		if (v > CH_MAX)
			v = CH_MAX;
		return v[CH_W-1:0];
	endfunction

	function automatic longint unsigned wrap_sextant(input longint unsigned t);
		return (t >= 6 * ONE_Q) ? t - 6 * ONE_Q : t;
	endfunction

	function automatic pixel_word_t predict_pixel(input logic [HUE_W-1:0] hue,
		input logic [REG_W-1:0] sat_reg, input logic [REG_W-1:0] light_reg);
		longint unsigned s;
		longint unsigned l;
		longint unsigned ls;
		longint unsigned h6;
		longint m2s;
		longint m1s;
		pixel_word_t w;
		s = (sat_reg > ONE_Q) ? ONE_Q : sat_reg;
		l = (light_reg > ONE_Q) ? ONE_Q : light_reg;
		ls = (l * s) >> FRAC_BITS_DEF;
		if (2 * l < ONE_Q)
			m2s = longint'(l) + longint'(ls);
		else
			m2s = longint'(l) + longint'(s) - longint'(ls);
		if (m2s < 0)
			m2s = 0;
		if (m2s > longint'(ONE_Q))
			m2s = ONE_Q;
		m1s = 2 * longint'(l) - m2s;
		if (m1s < 0)
			m1s = 0;
		if (m1s > m2s)
			m1s = m2s;
		// Six sextants per turn, so a third of a turn is exactly two of them.
		h6 = 6 * (longint'(hue) & (ONE_Q - 1));
		w.red   = ramp_level(m1s, m2s, wrap_sextant(h6 + 2 * ONE_Q));
		w.green = ramp_level(m1s, m2s, h6);
		w.blue  = ramp_level(m1s, m2s, wrap_sextant(h6 + 4 * ONE_Q));
		w.pixel = {ALPHA, w.blue, w.green, w.red};
		return w;
	endfunction

	task automatic report_field(input string name, input logic [PIX_W-1:0] exp_v,
		input logic [PIX_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Output side: checks every accepted word and throttles ready in bursts.
	initial begin
		pixel_word_t exp_w;
		int unsigned stall_left;
		logic rdy;
		stall_left = 0;
		pixel_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pixel_chan.valid && pixel_chan.ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none actual %h", $time,
						pixel_chan.pixel);
				end else begin
					exp_w = expected_pixels.pop_front();
					report_field("pixel", exp_w.pixel, pixel_chan.pixel);
					report_field("red", PIX_W'(exp_w.red), PIX_W'(pixel_chan.red));
					report_field("green", PIX_W'(exp_w.green), PIX_W'(pixel_chan.green));
					report_field("blue", PIX_W'(exp_w.blue), PIX_W'(pixel_chan.blue));
				end
			end
			if (!stalls_on) begin
				rdy = 1'b1;
				stall_left = 0;
			end else if (stall_left != 0) begin
				rdy = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 9) == 0) begin
				rdy = 1'b0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				rdy = 1'b1;
			end
			pixel_chan.ready <= rdy;
		end
	end

	// Called at a rising edge; returns at the edge that takes the hue, valid still high.
	task automatic send_hue(input logic [HUE_W-1:0] h);
		hue_chan.valid <= 1'b1;
		hue_chan.hue   <= h;
		do
			@(posedge clk);
		while (!hue_chan.ready);
		expected_pixels.push_back(predict_pixel(h, sat_setting, light_setting));
	endtask

	task automatic sender_gap();
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			hue_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		hue_chan.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		wait_drained();
		repeat (NSTG + 2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SAT)
			sat_setting = value;
		else
			light_setting = value;
	endtask

	function automatic logic [REG_W-1:0] pick_setting();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return REG_W'(ONE_Q);
			2: return '1;
			3: return ($urandom_range(0, 1) != 0) ? REG_W'(ONE_Q / 2) : REG_W'(ONE_Q / 2 - 1);
			default: return REG_W'($urandom_range(0, (1 << REG_W) - 1));
		endcase
	endfunction

	function automatic logic [HUE_W-1:0] pick_hue();
		int unsigned k;
		if ($urandom_range(0, 7) == 0) begin
			// Land on or next to a sextant boundary.
			k = $urandom_range(1, 5);
			return HUE_W'((k * ONE_Q) / 6 + $urandom_range(0, 2) - 1);
		end
		return HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
	endfunction

	task automatic test_reset_settings();
		logic [HUE_W-1:0] hues[11];
		hues = '{0, 4095, 682, 683, 1365, 1366, 2048, 2730, 2731, 3413, 3414};
		foreach (hues[i])
			send_hue(hues[i]);
	endtask

	task automatic test_register_extremes();
		logic [REG_W-1:0] sats[6];
		logic [REG_W-1:0] lights[6];
		sats   = '{0, 4096, 4096, 8191, 4096, 2048};
		lights = '{2048, 0, 4096, 8191, 2047, 1024};
		foreach (sats[i]) begin
			cfg_write(CFG_SAT, sats[i]);
			cfg_write(CFG_LIGHT, lights[i]);
			send_hue(0);
			send_hue(4095);
		end
	endtask

	task automatic test_random_settings();
		repeat (12) begin
			cfg_write(CFG_SAT, pick_setting());
			cfg_write(CFG_LIGHT, pick_setting());
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			repeat (100) begin
				sender_gap();
				send_hue(pick_hue());
			end
		end
	endtask

	task automatic test_drain_pause();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (40) begin
			sender_gap();
			send_hue(pick_hue());
		end
		wait_drained();
		repeat (40) begin
			sender_gap();
			send_hue(pick_hue());
		end
	endtask

	task automatic test_back_to_back();
		cfg_write(CFG_SAT, REG_W'($urandom_range(0, (1 << REG_W) - 1)));
		cfg_write(CFG_LIGHT, REG_W'($urandom_range(0, (1 << REG_W) - 1)));
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		repeat (200)
			send_hue(pick_hue());
	endtask

	initial begin
		hue_chan.valid <= 1'b0;
		hue_chan.hue   <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_SAT;
		cfg_data       <= '0;
		arst_n         <= 1'b0;
		sat_setting   = SAT_RST;
		light_setting = LIGHT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_register_extremes();
		test_random_settings();
		test_drain_pause();
		test_back_to_back();

		wait_drained();
		repeat (2 * NSTG) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
